[rtl/core/mmmu_pkg.sv]
package mmmu_pkg;

  // Window geometry
  localparam int CHANNELS = 5;
  localparam int WINDOW   = 5;

  localparam int SAMPLE_W = 32;
  localparam int CHAN_W   = 3;
  localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RANK_W   = $clog2(WINDOW) + 1;

  // Middle rank of a sorted window
  localparam logic [RANK_W-1:0] MID_RANK = RANK_W'(WINDOW / 2);

  // Channel limit, one bit wider than the channel field
  localparam logic [CHAN_W:0] CHAN_LIMIT = (CHAN_W + 1)'(CHANNELS);

  // Operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_FILL = 1'b1;

  typedef logic signed [SAMPLE_W-1:0]        sample_t;
  typedef logic [WINDOW-1:0][SAMPLE_W-1:0]   win_t;
  typedef logic [IDX_W-1:0]                  idx_t;

endpackage

[rtl/core/mmmu_req_if.sv]
interface mmmu_req_if;
  logic                             valid;
  logic                             ready;
  logic                             opcode;
  logic [mmmu_pkg::CHAN_W-1:0]      channel;
  logic signed [mmmu_pkg::SAMPLE_W-1:0] sample_value;

  modport source (output valid, output opcode, output channel, output sample_value,
                  input ready);
  modport sink   (input valid, input opcode, input channel, input sample_value,
                  output ready);
endinterface

[rtl/core/mmmu_rsp_if.sv]
interface mmmu_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mmmu_pkg::SAMPLE_W-1:0] median_value;

  modport source (output valid, output median_value, input ready);
  modport sink   (input valid, input median_value, output ready);
endinterface

[rtl/core/multichannel_moving_median_unit.sv]
// Channel  Dir  Width  Fields
// req_i    in   36     opcode(1), channel(3), sample_value(32, signed)
// rsp_o    out  32     median_value(32, signed)
//
// One request per cycle while rsp_o is not held; a push has its median on rsp_o
// via s1, s2 and output regs (window row read, shift and write-back, rank select).
// Window rows live in a one-row-per-channel RAM with registered read; a write-back
// to the same channel as the following request is forwarded.
// Reset clears the per-row valid bits at once; an unwritten row reads as zero.
// A held response stalls the stages behind it only as far as needed; fills and
// out-of-range channels produce no response.
module multichannel_moving_median_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  mmmu_req_if.sink    req_i,
  mmmu_rsp_if.source  rsp_o
);

  // Window RAM and row valid bits
  mmmu_pkg::win_t                   mem_q [mmmu_pkg::CHANNELS];
  logic [mmmu_pkg::CHANNELS-1:0]    row_vld_q;

  // Read stage (s1)
  logic                 s1_valid_q;
  logic                 s1_op_q;
  mmmu_pkg::idx_t       s1_idx_q;
  mmmu_pkg::sample_t    s1_sample_q;
  mmmu_pkg::win_t       rd_row_q;
  logic                 rd_vld_q;
  logic                 fwd_q;

  // Last written row, for forwarding
  mmmu_pkg::win_t       wr_row_q;

  // Median stage (s2)
  logic                 s2_valid_q;
  mmmu_pkg::win_t       s2_win_q;

  // Output register
  logic                 rsp_valid_q;
  mmmu_pkg::sample_t    median_q;

  logic                 req_acc;
  logic                 in_range;
  mmmu_pkg::idx_t       req_idx;
  logic                 out_free;
  logic                 s2_free;
  logic                 s1_adv;
  mmmu_pkg::win_t       old_row;
  mmmu_pkg::win_t       new_row;
  mmmu_pkg::sample_t    median_d;

  // Handshake and stage advance
  assign out_free  = !rsp_valid_q || rsp_o.ready;
  assign s2_free   = !s2_valid_q || out_free;
  assign s1_adv    = s1_valid_q && ((s1_op_q == mmmu_pkg::OP_FILL) || s2_free);
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign req_acc   = req_i.valid && req_i.ready;
  assign in_range  = ({1'b0, req_i.channel} < mmmu_pkg::CHAN_LIMIT);
  assign req_idx   = req_i.channel[mmmu_pkg::IDX_W-1:0];

  // RAM read, registered
  always_ff @(posedge clk_i) begin
    if (req_acc && in_range) begin
      rd_row_q <= mem_q[req_idx];
    end
  end

  // RAM write-back
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      mem_q[s1_idx_q] <= new_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (s1_adv) begin
      row_vld_q[s1_idx_q] <= 1'b1;
    end
  end

  // Read stage control; forward when the row is written at the read edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
      rd_vld_q   <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_acc && in_range;
      if (req_acc && in_range) begin
        fwd_q    <= s1_adv && (s1_idx_q == req_idx);
        rd_vld_q <= row_vld_q[req_idx];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc && in_range) begin
      s1_op_q     <= req_i.opcode;
      s1_idx_q    <= req_idx;
      s1_sample_q <= req_i.sample_value;
    end
    if (s1_adv) begin
      wr_row_q <= new_row;
    end
  end

  // Shift or fill the window row
  always_comb begin
    if (fwd_q) begin
      old_row = wr_row_q;
    end else if (rd_vld_q) begin
      old_row = rd_row_q;
    end else begin
      old_row = '0;
    end
    if (s1_op_q == mmmu_pkg::OP_FILL) begin
      new_row = {mmmu_pkg::WINDOW{s1_sample_q}};
    end else begin
      new_row = {s1_sample_q, old_row[mmmu_pkg::WINDOW-1:1]};
    end
  end

  // Median stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_free) begin
      s2_valid_q <= s1_adv && (s1_op_q == mmmu_pkg::OP_PUSH);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free && s1_adv) begin
      s2_win_q <= new_row;
    end
  end

  // Rank each entry (ties broken by slot) and pick the middle one
  always_comb begin
    logic [mmmu_pkg::RANK_W-1:0] rank;
    median_d = '0;
    for (int i = 0; i < mmmu_pkg::WINDOW; i++) begin
      rank = '0;
      for (int j = 0; j < mmmu_pkg::WINDOW; j++) begin
        if (j != i) begin
          if (($signed(s2_win_q[j]) < $signed(s2_win_q[i])) ||
              ((s2_win_q[j] == s2_win_q[i]) && (j < i))) begin
            rank = rank + 1'b1;
          end
        end
      end
      if (rank == mmmu_pkg::MID_RANK) begin
        median_d = s2_win_q[i];
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (out_free) begin
      rsp_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s2_valid_q) begin
      median_q <= median_d;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.median_value = median_q;

endmodule
